// File: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Types and codes shared by the sorted timer queue and its chain cells.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int SLOT_W  = 4;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    OP_SET_PERIOD = 3'd0,
    OP_START      = 3'd1,
    OP_STOP       = 3'd2,
    OP_RESTART    = 3'd3,
    OP_PROCESS    = 3'd4
  } opcode_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_POP    = 2'd2,
    CMD_INSERT = 2'd3
  } chain_cmd_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_INSERT = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [SLOT_W-1:0] slot_id;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic               fired;
    logic [SLOT_W-1:0]  fired_slot;
    logic               start_ignored;
    logic [COUNT_W-1:0] queued_count;
  } out_word_t;

  // One queue position: which slot sits there and when it expires.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef struct packed {
    chain_cmd_e        cmd;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] expiry;
  } chain_ctl_t;

endpackage

// File: rtl/stq_cell.sv
// ----------------------------------------------------------------------------
// stq_cell
// One position of the sorted queue; trades its entry with its neighbors.
// ----------------------------------------------------------------------------
module stq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  stq_pkg::chain_ctl_t ctl,
  input  logic                head_i,
  input  stq_pkg::entry_t     left_i,
  input  logic                left_shift_i,
  input  logic                left_rm_i,
  input  stq_pkg::entry_t     right_i,
  output stq_pkg::entry_t     entry_o,
  output logic                shift_o,
  output logic                rm_o
);

  logic                       valid_r, valid_nxt;
  logic [stq_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [stq_pkg::TIME_W-1:0] expiry_r, expiry_nxt;
  logic                       match;

  assign entry_o.valid  = valid_r;
  assign entry_o.slot   = slot_r;
  assign entry_o.expiry = expiry_r;

  assign match = valid_r && (slot_r == ctl.slot);
  // Set in this cell and all cells to its right once the removed slot is found.
  assign rm_o  = left_rm_i || match;
  // The head keeps ties; every other cell yields to an equal newcomer.
  assign shift_o = valid_r && (head_i ? (ctl.expiry < expiry_r) : (expiry_r >= ctl.expiry));

  always_comb begin
    valid_nxt  = valid_r;
    slot_nxt   = slot_r;
    expiry_nxt = expiry_r;
    case (ctl.cmd)
      stq_pkg::CMD_REMOVE: begin
        if (rm_o) begin
          valid_nxt  = right_i.valid;
          slot_nxt   = right_i.slot;
          expiry_nxt = right_i.expiry;
        end
      end
      stq_pkg::CMD_POP: begin
        valid_nxt  = right_i.valid;
        slot_nxt   = right_i.slot;
        expiry_nxt = right_i.expiry;
      end
      stq_pkg::CMD_INSERT: begin
        if (left_shift_i) begin
          valid_nxt  = left_i.valid;
          slot_nxt   = left_i.slot;
          expiry_nxt = left_i.expiry;
        end else if (shift_o || (!valid_r && (head_i || left_i.valid))) begin
          valid_nxt  = 1'b1;
          slot_nxt   = ctl.slot;
          expiry_nxt = ctl.expiry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    expiry_r <= expiry_nxt;
  end

endmodule

// File: rtl/sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Timer slots kept in order of absolute expiry in a chain of queue cells.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Word
//   in_      input      in_valid/in_ready   opcode, slot_id, period, now_time
//   out_     output     out_valid/out_ready fired, fired_slot, start_ignored,
//                                           queued_count
//
// Every word is handled in order: the accept cycle removes, pops or looks up the
// slot in the chain, and the insert state then inserts the slot and loads the
// result register. The two-step restart (remove, then insert) sets this order.
// A synchronous reset empties the queue and zeroes all reload periods at once;
// no clearing pass is needed. A stalled result only holds the insert state;
// the next word can be accepted while the last result still waits.
//
module sorted_timer_queue #(
  parameter int NUM_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  stq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output stq_pkg::out_word_t out_word
);

  // The slot field is four bits wide, so no more than sixteen periods are kept.
  localparam int PER_DEPTH = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
  localparam int PER_W     = $clog2(PER_DEPTH);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  stq_pkg::state_e            state_r, state_nxt;
  stq_pkg::chain_ctl_t        ctl;
  stq_pkg::entry_t            entries [NUM_SLOTS];
  logic                       shifts  [NUM_SLOTS];
  logic                       rms     [NUM_SLOTS];

  logic [stq_pkg::TIME_W-1:0] period_r [PER_DEPTH];
  logic [CNT_W-1:0]           count_r, count_nxt;

  // Word held between the lookup cycle and the insert cycle.
  logic [2:0]                 op_r;
  logic [stq_pkg::SLOT_W-1:0] slot_r;
  logic [stq_pkg::TIME_W-1:0] now_r;
  logic                       ok_r;
  logic                       found_r;
  logic                       fired_r;
  logic [stq_pkg::SLOT_W-1:0] fslot_r;

  logic                       out_valid_r;
  stq_pkg::out_word_t         out_word_r;

  logic                       in_fire;
  logic                       in_ok;
  logic                       head_due;
  logic                       out_free;
  logic                       commit;
  logic                       do_insert;
  logic [stq_pkg::TIME_W-1:0] ins_expiry;

  assign in_ready  = (state_r == stq_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || out_ready;

  // Out-of-range slots turn every operation except process into a no-op.
  assign in_ok    = (32'(in_word.slot_id) < NUM_SLOTS);
  assign head_due = entries[0].valid && (in_word.now_time >= entries[0].expiry);

  // Insertion uses the period as it stands after the lookup cycle.
  assign ins_expiry = now_r + period_r[PER_W'(slot_r)];
  assign do_insert  = ok_r && (((op_r == stq_pkg::OP_START) && !found_r) ||
                               (op_r == stq_pkg::OP_RESTART)) &&
                      (count_r != CNT_W'(NUM_SLOTS));

  // The queue cells. The head has no left neighbor, the tail none on its right.
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    stq_pkg::entry_t left_e, right_e;
    logic            left_sh, left_rm;

    if (i == 0) begin : g_head
      assign left_e  = '0;
      assign left_sh = 1'b0;
      assign left_rm = 1'b0;
    end else begin : g_body
      assign left_e  = entries[i-1];
      assign left_sh = shifts[i-1];
      assign left_rm = rms[i-1];
    end

    if (i == NUM_SLOTS - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entries[i+1];
    end

    stq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .head_i       (i == 0),
      .left_i       (left_e),
      .left_shift_i (left_sh),
      .left_rm_i    (left_rm),
      .right_i      (right_e),
      .entry_o      (entries[i]),
      .shift_o      (shifts[i]),
      .rm_o         (rms[i])
    );
  end

  // Command sequencing: lookup/remove on accept, then insert and report.
  always_comb begin
    ctl        = '0;
    ctl.cmd    = stq_pkg::CMD_HOLD;
    state_nxt  = state_r;
    commit     = 1'b0;
    count_nxt  = count_r;
    unique case (state_r)
      stq_pkg::ST_IDLE: begin
        ctl.slot = in_word.slot_id;
        if (in_fire) begin
          state_nxt = stq_pkg::ST_INSERT;
          unique case (in_word.opcode) inside
            stq_pkg::OP_SET_PERIOD, stq_pkg::OP_STOP, stq_pkg::OP_RESTART: begin
              if (in_ok) begin
                ctl.cmd = stq_pkg::CMD_REMOVE;
                if (rms[NUM_SLOTS-1]) begin
                  count_nxt = count_r - 1'b1;
                end
              end
            end
            stq_pkg::OP_PROCESS: begin
              if (head_due) begin
                ctl.cmd   = stq_pkg::CMD_POP;
                count_nxt = count_r - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      stq_pkg::ST_INSERT: begin
        ctl.slot   = slot_r;
        ctl.expiry = ins_expiry;
        if (out_free) begin
          commit    = 1'b1;
          state_nxt = stq_pkg::ST_IDLE;
          if (do_insert) begin
            ctl.cmd   = stq_pkg::CMD_INSERT;
            count_nxt = count_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = stq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Reload periods reset to zero and are written by set period.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PER_DEPTH; k++) begin
        period_r[k] <= '0;
      end
    end else if (in_fire && in_ok && (in_word.opcode == stq_pkg::OP_SET_PERIOD)) begin
      period_r[PER_W'(in_word.slot_id)] <= in_word.period;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r    <= in_word.opcode;
      slot_r  <= in_word.slot_id;
      now_r   <= in_word.now_time;
      ok_r    <= in_ok;
      found_r <= in_ok && (in_word.opcode == stq_pkg::OP_START) && rms[NUM_SLOTS-1];
      fired_r <= (in_word.opcode == stq_pkg::OP_PROCESS) && head_due;
      fslot_r <= ((in_word.opcode == stq_pkg::OP_PROCESS) && head_due) ?
                 entries[0].slot : '0;
    end
    if (commit) begin
      out_word_r.fired         <= fired_r;
      out_word_r.fired_slot    <= fslot_r;
      out_word_r.start_ignored <= found_r;
      out_word_r.queued_count  <= stq_pkg::COUNT_W'(count_nxt);
    end
  end

  // The fill count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NUM_SLOTS))
    else $error("queue count exceeds number of cells");

  // The head cell holds an entry exactly when the count is not zero.
  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    entries[0].valid == (count_r != '0))
    else $error("head valid disagrees with queue count");

  // An accepted word always moves on to the insert cycle.
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == stq_pkg::ST_INSERT))
    else $error("accepted word did not reach insert cycle");

  // A result never reports both a firing and an ignored start.
  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_word_r.fired && out_word_r.start_ignored))
    else $error("fired and start_ignored both set");

endmodule
